### rtl/datl_pkg.sv
package datl_pkg;

   localparam int VEL_W    = 16;
   localparam int TRIG_W   = 16;
   localparam int LEAN_W   = 16;
   localparam int STICK_W  = 14;
   localparam int THR_W    = 13;
   localparam int ROLL_W   = 15;
   localparam int PITCH_W  = 16;
   localparam int YAW_W    = 18;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   // Shared multiplier operand and product widths.
   localparam int MA_W     = 32;
   localparam int MB_W     = 19;
   localparam int P_W      = MA_W + MB_W;

   // Yaw-rate division by 164710400 = 2^11 * 80425. The rounded magnitude is
   // shifted right by 11 and then divided by 80425 through a reciprocal multiply
   // with one correction step.
   localparam int NUM_W    = 45;
   localparam int YQ_W     = 33;
   localparam int Q_W      = 18;
   localparam logic [NUM_W-1:0] YAW_HALF = 45'd82355200;
   localparam int DEN_SHIFT = 11;
   localparam int DEN_ODD   = 80425;
   localparam int RECIP_DEN = 213613;   // floor(2^32 / (80425 / 4))

   localparam int ROLL_LIM = 12868;
   localparam int FWD_CAP  = 5120;
   localparam int FWD_FULL = 12800;
   localparam int K_KEEP   = 62915;
   localparam int K_STICK  = 7496;
   localparam int RECIP6   = 174763;   // ceil(2^20 / 6)
   localparam int ASSIST_BASE = 4915;
   localparam int THR_MID  = 2048;
   localparam int THR_FULL = 4096;

   // Register indexes.
   localparam logic [2:0] REG_YAW_RATE_MAX  = 3'd0;
   localparam logic [2:0] REG_SPEED_LIMIT   = 3'd1;
   localparam logic [2:0] REG_SPEED_GAIN    = 3'd2;
   localparam logic [2:0] REG_BRAKE_STEP    = 3'd3;
   localparam logic [2:0] REG_ASSIST_GAIN   = 3'd4;
   localparam logic [2:0] REG_ASSIST_MAX    = 3'd5;
   localparam logic [2:0] REG_THROTTLE_LOW  = 3'd6;
   localparam logic [2:0] REG_THROTTLE_HIGH = 3'd7;

endpackage

### rtl/drift_attitude_target_loop.sv
// A request runs through seventeen sequencer steps on one shared 32 x 19 multiplier:
// thirteen multiplies for the attitude terms, two that divide the yaw product by a reciprocal
// multiply, one correction step and one step that loads the output register.
// req_stall is high whenever the sequencer is not idle, so a new request is taken only after
// the previous result has left the last step. A result that finds the output
// register held by rsp_stall waits in the last step, and req_stall stays high meanwhile.
// Reset (synchronous, active high) restores register defaults and clears the filter and brake state.
module drift_attitude_target_loop (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [datl_pkg::VEL_W-1:0]     req_vel_north,
   input  logic signed [datl_pkg::VEL_W-1:0]     req_vel_east,
   input  logic signed [datl_pkg::VEL_W-1:0]     req_vel_down,
   input  logic signed [datl_pkg::TRIG_W-1:0]    req_sin_yaw,
   input  logic signed [datl_pkg::TRIG_W-1:0]    req_cos_yaw,
   input  logic signed [datl_pkg::LEAN_W-1:0]    req_pilot_roll,
   input  logic signed [datl_pkg::LEAN_W-1:0]    req_pilot_pitch,
   input  logic signed [datl_pkg::STICK_W-1:0]   req_yaw_stick,
   input  logic        [datl_pkg::THR_W-1:0]     req_pilot_throttle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [datl_pkg::ROLL_W-1:0]    rsp_target_roll,
   output logic signed [datl_pkg::PITCH_W-1:0]   rsp_target_pitch,
   output logic signed [datl_pkg::YAW_W-1:0]     rsp_target_yaw_rate,
   output logic        [datl_pkg::THR_W-1:0]     rsp_throttle_out,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic        [datl_pkg::ADDR_W-1:0]    paddr,
   input  logic        [datl_pkg::DATA_W-1:0]    pwdata,
   output logic        [datl_pkg::DATA_W-1:0]    prdata,
   output logic                                  pready
);
   import datl_pkg::*;

   // Sequencer codes: one state per multiply step, the yaw correction step, then the
   // step that hands the result to the output register.
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_M0   = 5'd1;
   localparam logic [4:0] S_M1   = 5'd2;
   localparam logic [4:0] S_M2   = 5'd3;
   localparam logic [4:0] S_M3   = 5'd4;
   localparam logic [4:0] S_M4   = 5'd5;
   localparam logic [4:0] S_M5   = 5'd6;
   localparam logic [4:0] S_M6   = 5'd7;
   localparam logic [4:0] S_M7   = 5'd8;
   localparam logic [4:0] S_M8   = 5'd9;
   localparam logic [4:0] S_M9   = 5'd10;
   localparam logic [4:0] S_M10  = 5'd11;
   localparam logic [4:0] S_M11  = 5'd12;
   localparam logic [4:0] S_M12  = 5'd13;
   localparam logic [4:0] S_M13  = 5'd14;
   localparam logic [4:0] S_D1   = 5'd15;
   localparam logic [4:0] S_D2   = 5'd16;
   localparam logic [4:0] S_WAIT = 5'd17;

   logic [4:0] state_ff, state_in;

   // Configuration registers.
   logic [14:0] yaw_rate_max_ff, speed_limit_ff;
   logic [15:0] speed_gain_ff, brake_step_ff, assist_gain_ff;
   logic [12:0] assist_max_ff, throttle_low_ff, throttle_high_ff;

   // Captured request.
   logic signed [VEL_W-1:0]   vn_ff, ve_ff, vd_ff;
   logic signed [TRIG_W-1:0]  sn_ff, cs_ff;
   logic signed [LEAN_W-1:0]  pr_ff, pp_ff;
   logic signed [STICK_W-1:0] stick_ff;
   logic        [THR_W-1:0]   thr_ff;

   // Datapath registers.
   logic signed [P_W-1:0]     p_ff, acc_ff;
   logic signed [18:0]        right_raw_ff, fwd_raw_ff;
   logic signed [15:0]        right_c_ff, fwd_c_ff;
   logic signed [15:0]        filt_ff;
   logic        [15:0]        brake_ff;
   logic signed [ROLL_W-1:0]  roll_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic        [THR_W-1:0]   thr_out_ff;

   // Yaw-rate division.
   logic [YQ_W-1:0]           y_ff;
   logic [Q_W-1:0]            q_ff;
   logic                      neg_ff;

   // Output register.
   logic                      rsp_valid_ff;
   logic signed [ROLL_W-1:0]  rsp_roll_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;
   logic signed [YAW_W-1:0]   rsp_yaw_ff;
   logic        [THR_W-1:0]   rsp_thr_ff;

   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [P_W-1:0]     prod;

   logic                      req_take;
   logic                      rsp_free;
   logic                      cfg_write;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_target_roll     = rsp_roll_ff;
   assign rsp_target_pitch    = rsp_pitch_ff;
   assign rsp_target_yaw_rate = rsp_yaw_ff;
   assign rsp_throttle_out    = rsp_thr_ff;

   // Register reads.
   always_comb begin
      unique case (paddr[4:2])
         REG_YAW_RATE_MAX:  prdata = 32'(yaw_rate_max_ff);
         REG_SPEED_LIMIT:   prdata = 32'(speed_limit_ff);
         REG_SPEED_GAIN:    prdata = 32'(speed_gain_ff);
         REG_BRAKE_STEP:    prdata = 32'(brake_step_ff);
         REG_ASSIST_GAIN:   prdata = 32'(assist_gain_ff);
         REG_ASSIST_MAX:    prdata = 32'(assist_max_ff);
         REG_THROTTLE_LOW:  prdata = 32'(throttle_low_ff);
         REG_THROTTLE_HIGH: prdata = 32'(throttle_high_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_rate_max_ff  <= 15'd3619;
         speed_limit_ff   <= 15'd1434;
         speed_gain_ff    <= 16'd9151;
         brake_step_ff    <= 16'd1966;
         assist_gain_ff   <= 16'd11796;
         assist_max_ff    <= 13'd1229;
         throttle_low_ff  <= 13'd872;
         throttle_high_ff <= 13'd3224;
      end else if (cfg_write) begin
         unique case (paddr[4:2])
            REG_YAW_RATE_MAX:  yaw_rate_max_ff  <= pwdata[14:0];
            REG_SPEED_LIMIT:   speed_limit_ff   <= pwdata[14:0];
            REG_SPEED_GAIN:    speed_gain_ff    <= pwdata[15:0];
            REG_BRAKE_STEP:    brake_step_ff    <= pwdata[15:0];
            REG_ASSIST_GAIN:   assist_gain_ff   <= pwdata[15:0];
            REG_ASSIST_MAX:    assist_max_ff    <= pwdata[12:0];
            REG_THROTTLE_LOW:  throttle_low_ff  <= pwdata[12:0];
            REG_THROTTLE_HIGH: throttle_high_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   // Helper values for individual steps.
   logic signed [18:0] fwd_abs, fwd2, lim19, neg_lim19;
   logic signed [13:0] thr_dev;
   logic        [12:0] thr_dev_abs;
   logic        [17:0] div6_num;
   logic signed [P_W-1:0] num_abs;
   logic signed [18:0] a_w;
   logic        [12:0] a_val;

   assign fwd_abs   = fwd_raw_ff[18] ? -fwd_raw_ff : fwd_raw_ff;
   assign fwd2      = (fwd_abs > 19'sd5120) ? 19'(FWD_CAP) : fwd_abs;
   assign lim19     = signed'(19'(speed_limit_ff));
   assign neg_lim19 = -lim19;
   assign thr_dev   = signed'({1'b0, thr_ff}) - 14'sd2048;
   assign thr_dev_abs = thr_dev[13] ? 13'(-thr_dev) : thr_dev[12:0];
   assign div6_num  = 18'(thr_dev_abs) * 18'd25 + 18'd3;
   assign num_abs   = p_ff[P_W-1] ? -p_ff : p_ff;

   // Assist shape, clamped to 0..4096; it feeds the multiplier in the same step.
   assign a_w       = 19'sd4915 - signed'(19'(p_ff[37:20]));
   assign a_val     = a_w[18] ? 13'd0 :
                      ((a_w > 19'sd4096) ? 13'(THR_FULL) : 13'(a_w));

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_M0:  begin mul_a = MA_W'(ve_ff);    mul_b = MB_W'(cs_ff); end
         S_M1:  begin mul_a = MA_W'(vn_ff);    mul_b = MB_W'(sn_ff); end
         S_M2:  begin mul_a = MA_W'(ve_ff);    mul_b = MB_W'(sn_ff); end
         S_M3:  begin mul_a = MA_W'(vn_ff);    mul_b = MB_W'(cs_ff); end
         S_M4:  begin
            mul_a = MA_W'(pr_ff);
            mul_b = signed'(MB_W'(yaw_rate_max_ff));
         end
         S_M5:  begin
            mul_a = p_ff[MA_W-1:0];
            mul_b = 19'(FWD_FULL) - fwd2;
         end
         S_M6:  begin mul_a = MA_W'(filt_ff);  mul_b = 19'(K_KEEP); end
         S_M7:  begin mul_a = MA_W'(stick_ff); mul_b = 19'(K_STICK); end
         S_M8:  begin
            mul_a = MA_W'(right_c_ff);
            mul_b = signed'(MB_W'(speed_gain_ff));
         end
         S_M9:  begin
            mul_a = MA_W'(fwd_c_ff);
            mul_b = signed'(MB_W'(brake_ff));
         end
         S_M10: begin
            mul_a = MA_W'(RECIP6);
            mul_b = signed'(MB_W'(div6_num));
         end
         S_M11: begin
            mul_a = signed'(MA_W'(a_val));
            mul_b = signed'(MB_W'(assist_gain_ff));
         end
         S_M12: begin mul_a = p_ff[MA_W-1:0];  mul_b = MB_W'(vd_ff); end
         S_M13: begin mul_a = MA_W'(y_ff[YQ_W-1:2]); mul_b = 19'(RECIP_DEN); end
         S_D1:  begin mul_a = MA_W'(p_ff[Q_W+31:32]); mul_b = 19'(DEN_ODD); end
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;

   // Step results.
   logic signed [P_W-1:0] sum_r, sum_f, sum_k, sum_roll, sum_pitch, sum_asst;
   logic signed [18:0]    right_c19, fwd_c19;
   logic signed [34:0]    filt_w;
   logic signed [22:0]    roll_w;
   logic signed [21:0]    pitch_w;
   logic        [16:0]    brake_sum;
   logic        [15:0]    brake_new;
   logic signed [26:0]    asst_w;
   logic signed [13:0]    asst;
   logic signed [15:0]    thr_sum;
   logic                  in_window;

   assign sum_r     = acc_ff - p_ff + 51'sd8192;
   assign sum_f     = acc_ff + p_ff + 51'sd8192;
   assign sum_k     = acc_ff + p_ff + 51'sd32768;
   assign sum_roll  = p_ff + 51'sd512;
   assign sum_pitch = p_ff + 51'sd512;
   assign sum_asst  = p_ff + 51'sd8388608;

   assign right_c19 = (right_raw_ff > lim19) ? lim19 :
                      ((right_raw_ff < neg_lim19) ? neg_lim19 : right_raw_ff);
   assign fwd_c19   = (fwd_raw_ff > lim19) ? lim19 :
                      ((fwd_raw_ff < neg_lim19) ? neg_lim19 : fwd_raw_ff);

   assign filt_w    = 35'(sum_k >>> 16);
   assign roll_w    = 23'(filt_ff) - 23'(sum_roll >>> 10);
   assign pitch_w   = 22'(sum_pitch >>> 10);
   assign brake_sum = 17'(brake_ff) + 17'(brake_step_ff);
   assign brake_new = (brake_sum > 17'(speed_gain_ff)) ? speed_gain_ff : brake_sum[15:0];
   assign asst_w    = 27'(sum_asst >>> 24);
   assign asst      = (asst_w > signed'(27'(assist_max_ff))) ? signed'(14'(assist_max_ff)) :
                      ((asst_w < -signed'(27'(assist_max_ff))) ?
                       -signed'(14'(assist_max_ff)) : 14'(asst_w));
   assign thr_sum   = signed'(16'(thr_ff)) + 16'(asst);
   assign in_window = (thr_ff > throttle_low_ff) && (thr_ff < throttle_high_ff);

   // Yaw rate from the corrected quotient.
   logic signed [Q_W:0] yaw_w;
   logic signed [YAW_W-1:0] yaw_sat;
   logic [YQ_W-1:0] y_rem;
   assign yaw_w   = neg_ff ? -signed'({1'b0, q_ff}) : signed'({1'b0, q_ff});
   assign yaw_sat = (yaw_w > 19'sd131071) ? 18'sd131071 :
                    ((yaw_w < -19'sd131072) ? -18'sd131072 : yaw_w[YAW_W-1:0]);
   assign y_rem   = y_ff - p_ff[YQ_W-1:0];

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_take) state_in = S_M0;
         S_M0:    state_in = S_M1;
         S_M1:    state_in = S_M2;
         S_M2:    state_in = S_M3;
         S_M3:    state_in = S_M4;
         S_M4:    state_in = S_M5;
         S_M5:    state_in = S_M6;
         S_M6:    state_in = S_M7;
         S_M7:    state_in = S_M8;
         S_M8:    state_in = S_M9;
         S_M9:    state_in = S_M10;
         S_M10:   state_in = S_M11;
         S_M11:   state_in = S_M12;
         S_M12:   state_in = S_M13;
         S_M13:   state_in = S_D1;
         S_D1:    state_in = S_D2;
         S_D2:    state_in = S_WAIT;
         S_WAIT:  if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_take) begin
         vn_ff    <= req_vel_north;
         ve_ff    <= req_vel_east;
         vd_ff    <= req_vel_down;
         sn_ff    <= req_sin_yaw;
         cs_ff    <= req_cos_yaw;
         pr_ff    <= req_pilot_roll;
         pp_ff    <= req_pilot_pitch;
         stick_ff <= req_yaw_stick;
         thr_ff   <= req_pilot_throttle;
      end
   end

   // Datapath payload.
   always_ff @(posedge clock) begin
      if (state_ff != S_IDLE && state_ff != S_WAIT) begin
         p_ff <= prod;
      end
      case (state_ff)
         S_M1:  acc_ff <= p_ff;
         S_M2:  right_raw_ff <= 19'(sum_r >>> 14);
         S_M3:  acc_ff <= p_ff;
         S_M4:  fwd_raw_ff <= 19'(sum_f >>> 14);
         S_M5:  begin
            right_c_ff <= 16'(right_c19);
            fwd_c_ff   <= 16'(fwd_c19);
         end
         S_M7:  acc_ff <= p_ff;
         S_M9:  roll_ff <= (roll_w > 23'sd12868) ? 15'(ROLL_LIM) :
                           ((roll_w < -23'sd12868) ? -15'(ROLL_LIM) : 15'(roll_w));
         S_M10: begin
            if (pp_ff == '0) begin
               pitch_ff <= (pitch_w > 22'sd32767) ? 16'sh7fff :
                           ((pitch_w < -22'sd32768) ? 16'sh8000 : 16'(pitch_w));
            end else begin
               pitch_ff <= pp_ff;
            end
         end
         S_M13: begin
            if (!in_window) begin
               thr_out_ff <= (thr_ff > 13'd4096) ? 13'(THR_FULL) : thr_ff;
            end else if (thr_sum < 16'sd0) begin
               thr_out_ff <= 13'd0;
            end else if (thr_sum > 16'sd4096) begin
               thr_out_ff <= 13'(THR_FULL);
            end else begin
               thr_out_ff <= 13'(thr_sum);
            end
         end
         default: ;
      endcase
   end

   // Filter and brake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff  <= '0;
         brake_ff <= '0;
      end else if (state_ff == S_M8) begin
         filt_ff  <= (filt_w > 35'sd32767) ? 16'sh7fff :
                     ((filt_w < -35'sd32768) ? 16'sh8000 : 16'(filt_w));
         brake_ff <= (pp_ff == '0) ? brake_new : 16'd0;
      end
   end

   // Yaw-rate division. The rounded magnitude is shifted right by 11, the reciprocal
   // multiply gives a quotient that is exact or one low, and one compare fixes it.
   always_ff @(posedge clock) begin
      if (state_ff == S_M6) begin
         neg_ff <= p_ff[P_W-1];
         y_ff   <= YQ_W'((NUM_W'(num_abs) + YAW_HALF) >> DEN_SHIFT);
      end else if (state_ff == S_D1) begin
         q_ff   <= p_ff[Q_W+31:32];
      end else if (state_ff == S_D2 && y_rem >= YQ_W'(DEN_ODD)) begin
         q_ff   <= q_ff + Q_W'(1);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_WAIT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WAIT && rsp_free) begin
         rsp_roll_ff  <= roll_ff;
         rsp_pitch_ff <= pitch_ff;
         rsp_yaw_ff   <= yaw_sat;
         rsp_thr_ff   <= thr_out_ff;
      end
   end

   // A request is never taken while the sequencer is working.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request accepted while busy");

   // The quotient correction step always leads to the final step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_D2) |=> (state_ff == S_WAIT))
      else $error("yaw correction step not followed by the final step");

   // A result is only loaded from the final step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_WAIT))
      else $error("result loaded outside the final step");

   // The brake gain never exceeds its cap after an update.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_M9) |-> (brake_ff <= speed_gain_ff))
      else $error("brake gain above cap");

endmodule
